/* sv/ps2g_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 gamepad package
// Shared types, scan code constants and key map functions for the
// scan code set 2 to gamepad parser.
// ----------------------------------------------------------------------------
package ps2g_pkg;

    // Widths of the transaction fields and of the parser state.
    localparam int CODE_W = 8;
    localparam int BTN_W  = 12;
    localparam int SKIP_W = 3;

    // Prefix and special scan codes.
    localparam logic [CODE_W-1:0] CODE_BREAK  = 8'hF0;
    localparam logic [CODE_W-1:0] CODE_EXT    = 8'hE0;
    localparam logic [CODE_W-1:0] CODE_PAUSE  = 8'hE1;
    localparam logic [CODE_W-1:0] CODE_PRTSC  = 8'h12;
    localparam logic [CODE_W-1:0] CODE_PRTSCB = 8'h7C;

    // Number of bytes swallowed by the long sequences.
    localparam logic [SKIP_W-1:0] SKIP_PAUSE  = 3'd7;
    localparam logic [SKIP_W-1:0] SKIP_PRTSC  = 3'd2;
    localparam logic [SKIP_W-1:0] SKIP_PRTSCB = 3'd3;

    // Button bit masks.
    localparam logic [BTN_W-1:0] BTN_B      = 12'h001;
    localparam logic [BTN_W-1:0] BTN_Y      = 12'h002;
    localparam logic [BTN_W-1:0] BTN_SELECT = 12'h004;
    localparam logic [BTN_W-1:0] BTN_START  = 12'h008;
    localparam logic [BTN_W-1:0] BTN_UP     = 12'h010;
    localparam logic [BTN_W-1:0] BTN_DOWN   = 12'h020;
    localparam logic [BTN_W-1:0] BTN_LEFT   = 12'h040;
    localparam logic [BTN_W-1:0] BTN_RIGHT  = 12'h080;
    localparam logic [BTN_W-1:0] BTN_A      = 12'h100;
    localparam logic [BTN_W-1:0] BTN_X      = 12'h200;
    localparam logic [BTN_W-1:0] BTN_L      = 12'h400;
    localparam logic [BTN_W-1:0] BTN_R      = 12'h800;
    localparam logic [BTN_W-1:0] BTN_NONE   = 12'h000;

    // Prefix tracking state.
    typedef enum logic [1:0] {
        PFX_IDLE   = 2'd0,
        PFX_EXT    = 2'd1,
        PFX_BRK    = 2'd2,
        PFX_EXTBRK = 2'd3
    } t_prefix;

    // Contents of the input register stage.
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } t_in_stage;

    // Key map for codes without the extended prefix.
    function automatic logic [BTN_W-1:0] plain_bit(input logic [CODE_W-1:0] code);
        logic [BTN_W-1:0] bits;
        bits = BTN_NONE;
        unique case (code)
            8'h1D, 8'h43: bits = BTN_UP;
            8'h1B, 8'h42: bits = BTN_DOWN;
            8'h1C, 8'h3B: bits = BTN_LEFT;
            8'h23, 8'h4B: bits = BTN_RIGHT;
            8'h69:        bits = BTN_Y;
            8'h72:        bits = BTN_B;
            8'h6B:        bits = BTN_X;
            8'h73:        bits = BTN_A;
            8'h7A:        bits = BTN_L;
            8'h74:        bits = BTN_R;
            8'h12:        bits = BTN_SELECT;
            8'h14:        bits = BTN_START;
            default:      bits = BTN_NONE;
        endcase
        return bits;
    endfunction

    // Key map for codes after the extended prefix.
    function automatic logic [BTN_W-1:0] ext_bit(input logic [CODE_W-1:0] code);
        logic [BTN_W-1:0] bits;
        bits = BTN_NONE;
        unique case (code)
            8'h75:   bits = BTN_UP;
            8'h72:   bits = BTN_DOWN;
            8'h6B:   bits = BTN_LEFT;
            8'h74:   bits = BTN_RIGHT;
            default: bits = BTN_NONE;
        endcase
        return bits;
    endfunction

endpackage

/* sv/ps2g_in_stage.sv */
// ----------------------------------------------------------------------------
// PS/2 gamepad input stage
// One-entry input register. It takes a new transaction whenever it is
// empty or its current byte moves on in the same cycle.
// ----------------------------------------------------------------------------
module ps2g_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ps2g_pkg::CODE_W-1:0] i_code,
    input  logic                        i_adv,
    output logic                        o_stall,
    output ps2g_pkg::t_in_stage         o_stage
);

    logic                        r_valid;
    logic                        n_valid;
    logic [ps2g_pkg::CODE_W-1:0] r_code;
    logic                        w_accept;

    // The register is full and its byte cannot move on.
    assign o_stall  = r_valid && !i_adv;
    assign w_accept = i_valid && !o_stall;

    // Occupancy of the register.
    always_comb begin
        n_valid = (r_valid && !i_adv) || w_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_code <= i_code;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.code  = r_code;

endmodule

/* sv/ps2g_parser.sv */
// ----------------------------------------------------------------------------
// PS/2 gamepad parser
// Holds the prefix state, skip count and button state, and works out the
// next values for one scan code byte. State moves when the byte advances.
// ----------------------------------------------------------------------------
module ps2g_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [ps2g_pkg::CODE_W-1:0] i_code,
    output logic [ps2g_pkg::BTN_W-1:0]  o_buttons,
    output logic                        o_mid
);

    ps2g_pkg::t_prefix           r_prefix;
    ps2g_pkg::t_prefix           n_prefix;
    logic [ps2g_pkg::SKIP_W-1:0] r_skip;
    logic [ps2g_pkg::SKIP_W-1:0] n_skip;
    logic [ps2g_pkg::BTN_W-1:0]  r_buttons;
    logic [ps2g_pkg::BTN_W-1:0]  n_buttons;
    logic                        w_skipping;

    assign w_skipping = (r_skip != '0);

    // Next prefix state.
    always_comb begin
        n_prefix = r_prefix;
        if (!w_skipping) begin
            unique case (r_prefix)
                ps2g_pkg::PFX_IDLE: begin
                    if (i_code == ps2g_pkg::CODE_BREAK) begin
                        n_prefix = ps2g_pkg::PFX_BRK;
                    end else if (i_code == ps2g_pkg::CODE_EXT) begin
                        n_prefix = ps2g_pkg::PFX_EXT;
                    end
                end
                ps2g_pkg::PFX_EXT: begin
                    if (i_code == ps2g_pkg::CODE_BREAK) begin
                        n_prefix = ps2g_pkg::PFX_EXTBRK;
                    end else begin
                        n_prefix = ps2g_pkg::PFX_IDLE;
                    end
                end
                ps2g_pkg::PFX_BRK,
                ps2g_pkg::PFX_EXTBRK: begin
                    n_prefix = ps2g_pkg::PFX_IDLE;
                end
                default: n_prefix = ps2g_pkg::PFX_IDLE;
            endcase
        end
    end

    // Skip count and button updates for the current byte.
    always_comb begin
        n_skip    = r_skip;
        n_buttons = r_buttons;
        if (w_skipping) begin
            n_skip = r_skip - ps2g_pkg::SKIP_W'(1);
        end else begin
            unique case (r_prefix)
                ps2g_pkg::PFX_IDLE: begin
                    if (i_code == ps2g_pkg::CODE_PAUSE) begin
                        n_skip = ps2g_pkg::SKIP_PAUSE;
                    end else if (i_code != ps2g_pkg::CODE_BREAK &&
                                 i_code != ps2g_pkg::CODE_EXT) begin
                        n_buttons = r_buttons | ps2g_pkg::plain_bit(i_code);
                    end
                end
                ps2g_pkg::PFX_EXT: begin
                    if (i_code == ps2g_pkg::CODE_PRTSC) begin
                        n_skip = ps2g_pkg::SKIP_PRTSC;
                    end else if (i_code != ps2g_pkg::CODE_BREAK) begin
                        n_buttons = r_buttons | ps2g_pkg::ext_bit(i_code);
                    end
                end
                ps2g_pkg::PFX_BRK: begin
                    n_buttons = r_buttons & ~ps2g_pkg::plain_bit(i_code);
                end
                ps2g_pkg::PFX_EXTBRK: begin
                    if (i_code == ps2g_pkg::CODE_PRTSCB) begin
                        n_skip = ps2g_pkg::SKIP_PRTSCB;
                    end else begin
                        n_buttons = r_buttons & ~ps2g_pkg::ext_bit(i_code);
                    end
                end
                default: n_skip = r_skip;
            endcase
        end
    end

    // State registers move only when a byte advances to the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix  <= ps2g_pkg::PFX_IDLE;
            r_skip    <= '0;
            r_buttons <= ps2g_pkg::BTN_NONE;
        end else if (i_adv) begin
            r_prefix  <= n_prefix;
            r_skip    <= n_skip;
            r_buttons <= n_buttons;
        end
    end

    // Result values after this byte.
    assign o_buttons = n_buttons;
    assign o_mid     = (n_prefix != ps2g_pkg::PFX_IDLE) || (n_skip != '0);

endmodule

/* sv/ps2g_out_stage.sv */
// ----------------------------------------------------------------------------
// PS/2 gamepad output stage
// Result register. It holds a result while the downstream side stalls and
// loads a new one whenever a byte advances.
// ----------------------------------------------------------------------------
module ps2g_out_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_stall,
    input  logic                       i_adv,
    input  logic [ps2g_pkg::BTN_W-1:0] i_buttons,
    input  logic                       i_mid,
    output logic                       o_free,
    output logic                       o_valid,
    output logic [ps2g_pkg::BTN_W-1:0] o_buttons,
    output logic                       o_mid
);

    logic                       r_valid;
    logic                       n_valid;
    logic [ps2g_pkg::BTN_W-1:0] r_buttons;
    logic                       r_mid;

    // The register can load when empty or when its result is being taken.
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = i_adv || (r_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_buttons <= i_buttons;
            r_mid     <= i_mid;
        end
    end

    assign o_valid   = r_valid;
    assign o_buttons = r_buttons;
    assign o_mid     = r_mid;

endmodule

/* sv/ps2_scancode_to_gamepad_top.sv */
// A byte is taken into the input register and then, with its result, into the
// result register; it waits longer only while the output side stalls.
// Throughput: one byte per cycle unless the output side stalls; the parser
// state register updates whenever a byte moves from input to result register.
// Reset: synchronous, active low; both stages empty, prefix idle, no bytes
// to skip, all buttons released.
// ----------------------------------------------------------------------------
// PS/2 scan code set 2 to gamepad top level
// Input register, parser and result register for a 12-button pad state.
// ----------------------------------------------------------------------------
module ps2_scancode_to_gamepad_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ps2g_pkg::CODE_W-1:0] i_scan_code,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ps2g_pkg::BTN_W-1:0]  o_buttons,
    output logic                        o_mid_sequence
);

    ps2g_pkg::t_in_stage        s_in;
    logic                       w_out_free;
    logic                       w_adv;
    logic [ps2g_pkg::BTN_W-1:0] w_buttons;
    logic                       w_mid;

    // A byte advances when the input register holds one and the result
    // register can take its result.
    assign w_adv = s_in.valid && w_out_free;

    // Input register.
    ps2g_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_code  (i_scan_code),
        .i_adv   (w_adv),
        .o_stall (o_in_stall),
        .o_stage (s_in)
    );

    // Parser state and decode.
    ps2g_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_code    (s_in.code),
        .o_buttons (w_buttons),
        .o_mid     (w_mid)
    );

    // Result register.
    ps2g_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stall   (i_out_stall),
        .i_adv     (w_adv),
        .i_buttons (w_buttons),
        .i_mid     (w_mid),
        .o_free    (w_out_free),
        .o_valid   (o_out_valid),
        .o_buttons (o_buttons),
        .o_mid     (o_mid_sequence)
    );

`ifndef SYNTHESIS
    // Reset empties both stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !s_in.valid)
        else $error("stages not empty after reset");

    // Every byte that advances produces a result in the next cycle.
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("advanced byte produced no result");

    // A byte held in the input register is kept until it advances.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && !w_adv |=> s_in.valid && $stable(s_in.code))
        else $error("held input byte lost or changed");
`endif

endmodule
